### hw/rtl/swvr_pkg.sv
package swvr_pkg;

  localparam int DEPTH  = 16;
  localparam int ADDR_W = $clog2(DEPTH);
  localparam int CNT_W  = $clog2(DEPTH + 1);

  localparam int VALUE_W     = 32;
  localparam int OUT_CNT_W   = 5;
  localparam int IN_TDATA_W  = 32;
  localparam int IN_TUSER_W  = 2;
  localparam int OUT_USED_W  = VALUE_W + 2 * OUT_CNT_W + 1;
  localparam int OUT_TDATA_W = ((OUT_USED_W + 7) / 8) * 8;
  localparam int OUT_TUSER_W = 2;

  typedef enum logic [1:0] {
    ACT_PUSH   = 2'd0,
    ACT_POP    = 2'd1,
    ACT_REMOVE = 2'd2,
    ACT_NONE   = 2'd3
  } action_t;

  typedef enum logic [1:0] {
    ST_OK        = 2'd0,
    ST_EMPTY     = 2'd1,
    ST_NOT_FOUND = 2'd2,
    ST_FULL      = 2'd3
  } status_t;

  typedef enum logic [1:0] {
    S_IDLE,
    S_POP_RD,
    S_SCAN,
    S_DONE
  } seq_state_t;

  typedef struct packed {
    logic               wr_en;
    logic [ADDR_W-1:0]  wr_addr;
    logic [VALUE_W-1:0] wr_data;
    logic               rd_en;
    logic [ADDR_W-1:0]  rd_addr;
  } mem_req_t;

  typedef struct packed {
    status_t               status;
    logic [VALUE_W-1:0]    popped;
    logic [OUT_CNT_W-1:0]  removed;
    logic [OUT_CNT_W-1:0]  count;
    logic                  is_empty;
  } result_t;

endpackage

### hw/rtl/swvr_ram.sv
module swvr_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic                     rd_en,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rd_data_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data_r <= mem[rd_addr];
    end
  end

  assign rd_data = rd_data_r;

endmodule

### hw/rtl/swvr_seq.sv
module swvr_seq
  import swvr_pkg::*;
(
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_ready,
  input  action_t            in_action,
  input  logic [VALUE_W-1:0] in_value,
  output mem_req_t           mem_req,
  input  logic [VALUE_W-1:0] rd_data,
  output logic               res_valid,
  input  logic               res_ready,
  output result_t            res
);

  seq_state_t         state_r, state_nxt;
  logic [VALUE_W-1:0] val_r, val_nxt;
  logic [CNT_W-1:0]   cnt_r, cnt_nxt;
  logic [CNT_W-1:0]   idx_r, idx_nxt;
  logic [CNT_W-1:0]   kept_r, kept_nxt;
  logic [CNT_W-1:0]   rm_r, rm_nxt;
  status_t            status_r, status_nxt;
  logic [VALUE_W-1:0] pop_r, pop_nxt;

  logic             accept;
  logic             is_full;
  logic             is_zero;
  logic             match;
  logic             scan_last;
  logic [CNT_W-1:0] kept_inc;
  logic [CNT_W-1:0] rm_inc;

  assign accept    = in_valid && in_ready;
  assign is_full   = (cnt_r == CNT_W'(DEPTH));
  assign is_zero   = (cnt_r == '0);
  assign match     = (rd_data == val_r);
  assign scan_last = (idx_r == cnt_r);
  assign kept_inc  = kept_r + CNT_W'(!match);
  assign rm_inc    = rm_r + CNT_W'(match);

  // next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          case (in_action)
            ACT_POP:    state_nxt = is_zero ? S_DONE : S_POP_RD;
            ACT_REMOVE: state_nxt = is_zero ? S_DONE : S_SCAN;
            default:    state_nxt = S_DONE;
          endcase
        end
      end
      S_POP_RD: state_nxt = S_DONE;
      S_SCAN: begin
        if (scan_last) begin
          state_nxt = S_DONE;
        end
      end
      S_DONE: begin
        if (res_ready) begin
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  // datapath and memory control
  always_comb begin
    in_ready   = 1'b0;
    res_valid  = 1'b0;
    mem_req    = '0;
    val_nxt    = val_r;
    cnt_nxt    = cnt_r;
    idx_nxt    = idx_r;
    kept_nxt   = kept_r;
    rm_nxt     = rm_r;
    status_nxt = status_r;
    pop_nxt    = pop_r;
    case (state_r)
      S_IDLE: begin
        in_ready = 1'b1;
        if (accept) begin
          val_nxt    = in_value;
          rm_nxt     = '0;
          pop_nxt    = '0;
          kept_nxt   = '0;
          idx_nxt    = CNT_W'(1);
          status_nxt = ST_OK;
          case (in_action)
            ACT_PUSH: begin
              if (is_full) begin
                status_nxt = ST_FULL;
              end else begin
                mem_req.wr_en   = 1'b1;
                mem_req.wr_addr = cnt_r[ADDR_W-1:0];
                mem_req.wr_data = in_value;
                cnt_nxt         = cnt_r + CNT_W'(1);
              end
            end
            ACT_POP: begin
              if (is_zero) begin
                status_nxt = ST_EMPTY;
              end else begin
                mem_req.rd_en   = 1'b1;
                mem_req.rd_addr = ADDR_W'(cnt_r - CNT_W'(1));
              end
            end
            ACT_REMOVE: begin
              if (is_zero) begin
                status_nxt = ST_NOT_FOUND;
              end else begin
                mem_req.rd_en   = 1'b1;
                mem_req.rd_addr = '0;
              end
            end
            default: begin
            end
          endcase
        end
      end
      S_POP_RD: begin
        pop_nxt = rd_data;
        cnt_nxt = cnt_r - CNT_W'(1);
        rm_nxt  = CNT_W'(1);
      end
      S_SCAN: begin
        // compact in place: write slot always trails the read slot
        mem_req.wr_en   = !match;
        mem_req.wr_addr = kept_r[ADDR_W-1:0];
        mem_req.wr_data = rd_data;
        kept_nxt        = kept_inc;
        rm_nxt          = rm_inc;
        if (scan_last) begin
          cnt_nxt    = kept_inc;
          status_nxt = (rm_inc == '0) ? ST_NOT_FOUND : ST_OK;
        end else begin
          mem_req.rd_en   = 1'b1;
          mem_req.rd_addr = idx_r[ADDR_W-1:0];
          idx_nxt         = idx_r + CNT_W'(1);
        end
      end
      S_DONE: begin
        res_valid = 1'b1;
      end
      default: begin
      end
    endcase
  end

  assign res.status   = status_r;
  assign res.popped   = pop_r;
  assign res.removed  = OUT_CNT_W'(rm_r);
  assign res.count    = OUT_CNT_W'(cnt_r);
  assign res.is_empty = is_zero;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      cnt_r   <= '0;
    end else begin
      state_r <= state_nxt;
      cnt_r   <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    val_r    <= val_nxt;
    idx_r    <= idx_nxt;
    kept_r   <= kept_nxt;
    rm_r     <= rm_nxt;
    status_r <= status_nxt;
    pop_r    <= pop_nxt;
  end

endmodule

### hw/rtl/swvr_outreg.sv
module swvr_outreg
  import swvr_pkg::*;
(
  input  logic    clk,
  input  logic    rst_n,
  input  logic    res_valid,
  output logic    res_ready,
  input  result_t res,
  output logic    out_valid,
  input  logic    out_ready,
  output result_t out_res
);

  logic    out_valid_r, out_valid_nxt;
  result_t out_res_r;

  assign res_ready = !out_valid_r || out_ready;

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (res_valid && res_ready) begin
      out_valid_nxt = 1'b1;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (res_valid && res_ready) begin
      out_res_r <= res;
    end
  end

  assign out_valid = out_valid_r;
  assign out_res   = out_res_r;

endmodule

### hw/rtl/stack_with_value_removal_unit.sv
// bounded stack of signed 32-bit values with removal of all equal entries
//
// input channel: in_tuser carries the action (push, pop, remove all equal),
// in_tdata the value (ignored for pop). one result item per request on the
// output channel: status in out_tuser, popped value, removed count, entry
// count and empty flag in out_tdata.
//
// path from accept to out_tvalid: push and unused action go through S_DONE
// and the output register; a pop reads in S_POP_RD first, a remove in S_SCAN.
// a remove reads every held entry once through the single read port of the
// entry memory and writes the survivors back compacted, one entry a cycle;
// that walk sets the rate. one request is processed at a time; in_tready
// is high only while the sequencer is free, and the next request is taken
// while a finished result still sits in the output register.
//
// reset empties the stack at once; entry memory contents are not cleared.
// when the receiver stalls, the result holds in the output register and the
// sequencer waits with the following result until that register frees up.
module stack_with_value_removal_unit
  import swvr_pkg::*;
(
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   in_tvalid,
  output logic                   in_tready,
  input  logic [IN_TDATA_W-1:0]  in_tdata,   // [31:0] value
  input  logic [IN_TUSER_W-1:0]  in_tuser,   // [1:0] action
  output logic                   out_tvalid,
  input  logic                   out_tready,
  output logic [OUT_TDATA_W-1:0] out_tdata,  // [31:0] popped_value, [36:32] removed_count,
                                             // [41:37] entry_count, [42] is_empty
  output logic [OUT_TUSER_W-1:0] out_tuser   // [1:0] status
);

  mem_req_t           mem_req;
  logic [VALUE_W-1:0] rd_data;
  logic               res_valid;
  logic               res_ready;
  result_t            res;
  result_t            out_res;

  swvr_seq u_seq (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_tvalid),
    .in_ready  (in_tready),
    .in_action (action_t'(in_tuser)),
    .in_value  (in_tdata[VALUE_W-1:0]),
    .mem_req   (mem_req),
    .rd_data   (rd_data),
    .res_valid (res_valid),
    .res_ready (res_ready),
    .res       (res)
  );

  swvr_ram #(
    .WIDTH (VALUE_W),
    .DEPTH (DEPTH)
  ) u_ram (
    .clk     (clk),
    .wr_en   (mem_req.wr_en),
    .wr_addr (mem_req.wr_addr),
    .wr_data (mem_req.wr_data),
    .rd_en   (mem_req.rd_en),
    .rd_addr (mem_req.rd_addr),
    .rd_data (rd_data)
  );

  swvr_outreg u_outreg (
    .clk       (clk),
    .rst_n     (rst_n),
    .res_valid (res_valid),
    .res_ready (res_ready),
    .res       (res),
    .out_valid (out_tvalid),
    .out_ready (out_tready),
    .out_res   (out_res)
  );

  assign out_tdata = {{(OUT_TDATA_W - OUT_USED_W){1'b0}}, out_res.is_empty,
                      out_res.count, out_res.removed, out_res.popped};
  assign out_tuser = out_res.status;

endmodule

### hw/rtl/swvr_chk.sv
module swvr_chk
  import swvr_pkg::*;
(
  input logic                   clk,
  input logic                   rst_n,
  input logic                   in_tvalid,
  input logic                   in_tready,
  input logic                   out_tvalid,
  input logic                   out_tready,
  input logic [OUT_TDATA_W-1:0] out_tdata,
  input logic [OUT_TUSER_W-1:0] out_tuser
);

  logic [VALUE_W-1:0]   o_pop;
  logic [OUT_CNT_W-1:0] o_rm;
  logic [OUT_CNT_W-1:0] o_cnt;
  logic                 o_empty;

  assign o_pop   = out_tdata[VALUE_W-1:0];
  assign o_rm    = out_tdata[VALUE_W +: OUT_CNT_W];
  assign o_cnt   = out_tdata[VALUE_W + OUT_CNT_W +: OUT_CNT_W];
  assign o_empty = out_tdata[VALUE_W + 2 * OUT_CNT_W];

  // one request at a time: the input closes right after an item is taken
  a_one_at_a_time: assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && in_tready |=> !in_tready)
    else $error("input still open after an accepted item");

  // stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata) && $stable(out_tuser))
    else $error("result changed while stalled");

  // empty flag agrees with the entry count
  a_empty_flag: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> (o_empty == (o_cnt == '0)))
    else $error("empty flag does not match entry count");

  // a full push leaves a full stack and removes nothing
  a_full_push: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tuser == ST_FULL |->
      o_rm == '0 && o_pop == '0 && o_cnt == OUT_CNT_W'(DEPTH))
    else $error("bad result for push on full stack");

  // a pop on an empty stack reports an empty stack
  a_empty_pop: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tuser == ST_EMPTY |-> o_empty && o_rm == '0 && o_pop == '0)
    else $error("bad result for pop on empty stack");

endmodule

bind stack_with_value_removal_unit swvr_chk u_swvr_chk (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_tvalid  (in_tvalid),
  .in_tready  (in_tready),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata),
  .out_tuser  (out_tuser)
);

### tb/stack_with_value_removal_unit_test.sv
module stack_with_value_removal_unit_test;
  import swvr_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  typedef struct {
    status_t              status;
    logic [VALUE_W-1:0]   popped;
    logic [OUT_CNT_W-1:0] removed;
    logic [OUT_CNT_W-1:0] held_after;
    logic                 empty;
  } outcome_t;

  class stack_tracker;
    logic [VALUE_W-1:0] slots [DEPTH];
    int                 held;
    outcome_t           pending_results[$];
    int                 fault_count;

    function new();
      held = 0;
      fault_count = 0;
    endfunction

    task flag_fault(string msg);
      $display("ERROR at %0t: %s", $time, msg);
      fault_count++;
    endtask

    // advance the stack by one accepted request and queue what it must return
    function void apply_request(action_t act, logic [VALUE_W-1:0] value);
      outcome_t o;
      int kept;
      int gone;
      o.status = ST_OK;
      o.popped = '0;
      o.removed = '0;
      case (act)
        ACT_PUSH: begin
          if (held >= DEPTH) begin
            o.status = ST_FULL;
          end else begin
            slots[held] = value;
            held++;
          end
        end
        ACT_POP: begin
          if (held == 0) begin
            o.status = ST_EMPTY;
          end else begin
            held--;
            o.popped = slots[held];
            o.removed = 1;
          end
        end
        ACT_REMOVE: begin
          kept = 0;
          gone = 0;
          for (int i = 0; i < held; i++) begin
            if (slots[i] == value) begin
              gone++;
            end else begin
              slots[kept] = slots[i];
              kept++;
            end
          end
          held = kept;
          o.removed = gone[OUT_CNT_W-1:0];
          if (gone == 0) o.status = ST_NOT_FOUND;
        end
        default: ;
      endcase
      o.held_after = held[OUT_CNT_W-1:0];
      o.empty = (held == 0);
      pending_results.push_back(o);
    endfunction

    task compare_result(logic [OUT_TUSER_W-1:0] tuser, logic [OUT_TDATA_W-1:0] tdata);
      outcome_t o;
      if (pending_results.size() == 0) begin
        flag_fault("result item arrived with nothing outstanding");
        return;
      end
      o = pending_results.pop_front();
      if (tuser !== o.status)
        flag_fault($sformatf("status got %0d want %0d", tuser, o.status));
      if (tdata[31:0] !== o.popped)
        flag_fault($sformatf("popped value got %h want %h", tdata[31:0], o.popped));
      if (tdata[36:32] !== o.removed)
        flag_fault($sformatf("removed count got %0d want %0d", tdata[36:32], o.removed));
      if (tdata[41:37] !== o.held_after)
        flag_fault($sformatf("entry count got %0d want %0d", tdata[41:37], o.held_after));
      if (tdata[42] !== o.empty)
        flag_fault($sformatf("empty flag got %b want %b", tdata[42], o.empty));
    endtask
  endclass

  logic                   clk;
  logic                   rst_n;
  logic                   in_tvalid;
  logic                   in_tready;
  logic [IN_TDATA_W-1:0]  in_tdata;
  logic [IN_TUSER_W-1:0]  in_tuser;
  logic                   out_tvalid;
  logic                   out_tready;
  logic [OUT_TDATA_W-1:0] out_tdata;
  logic [OUT_TUSER_W-1:0] out_tuser;

  stack_tracker tracker;
  bit           calm;
  bit           hold_now;

  stack_with_value_removal_unit dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser)
  );

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  initial begin
    #3_000_000;
    $display("stack_with_value_removal_unit: mismatch");
    $finish;
  end

  // offers one item, optionally after a random gap, and waits for it to be taken
  task send_request(action_t act, logic [VALUE_W-1:0] value);
    int gap;
    if (!calm && $urandom_range(0, 3) == 0) begin
      gap = $urandom_range(1, 18);
      @(negedge clk);
      in_tvalid <= 1'b0;
      repeat (gap - 1) @(negedge clk);
    end
    @(negedge clk);
    in_tvalid <= 1'b1;
    in_tuser  <= act;
    in_tdata  <= value;
    do @(posedge clk); while (in_tready !== 1'b1);
    tracker.apply_request(act, value);
  endtask

  // small signed pool so removes hit several entries, plus extremes and full-range values
  function logic [VALUE_W-1:0] pick_value();
    case ($urandom_range(0, 9))
      6:       return 32'h8000_0000;
      7:       return 32'h7fff_ffff;
      8, 9:    return $urandom;
      default: return $urandom_range(0, 6) - 3;
    endcase
  endfunction

  initial begin
    int stall;
    out_tready = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_now) begin
        // long hold-off so the block backs up and drops in_tready
        out_tready <= 1'b0;
        repeat (300) @(negedge clk);
        hold_now = 1'b0;
      end else if (!calm && $urandom_range(0, 4) == 0) begin
        out_tready <= 1'b0;
        stall = $urandom_range(1, 18);
        repeat (stall - 1) @(negedge clk);
      end else begin
        out_tready <= 1'b1;
      end
    end
  end

  always @(posedge clk) begin
    if (rst_n === 1'b1 && out_tvalid === 1'b1 && out_tready === 1'b1)
      tracker.compare_result(out_tuser, out_tdata);
  end

  initial begin
    action_t            act;
    logic [VALUE_W-1:0] value;
    int                 r;
    int                 push_pct;
    tracker   = new();
    calm      = 1'b0;
    hold_now  = 1'b0;
    rst_n     = 1'b0;
    in_tvalid = 1'b0;
    in_tdata  = '0;
    in_tuser  = ACT_PUSH;
    repeat (12) @(negedge clk);
    rst_n <= 1'b1;

    // empty-stack corners and the unused action code, then extreme values pushed, popped and removed
    send_request(ACT_POP, 32'hdead_beef);
    send_request(ACT_REMOVE, 32'h0000_0005);
    send_request(ACT_NONE, 32'hffff_ffff);
    send_request(ACT_PUSH, 32'h8000_0000);
    send_request(ACT_PUSH, 32'h7fff_ffff);
    send_request(ACT_PUSH, 32'hffff_ffff);
    send_request(ACT_PUSH, 32'h0000_0000);
    send_request(ACT_REMOVE, 32'h0000_0005);
    send_request(ACT_POP, 32'h0000_0000);
    send_request(ACT_REMOVE, 32'h7fff_ffff);
    // fill to the top with repeated values, push onto a full stack, then remove one repeated value
    for (int i = 0; i < DEPTH - 2; i++)
      send_request(ACT_PUSH, (i % 2 == 0) ? 32'h0000_0007 : 32'h5555_5555);
    send_request(ACT_PUSH, 32'h1234_5678);
    send_request(ACT_NONE, 32'h0000_0000);
    send_request(ACT_REMOVE, 32'h0000_0007);

    for (int k = 0; k < 450; k++) begin
      if (k == 100) hold_now = 1'b1;
      if (k == 370) calm = 1'b1;
      // alternate fill-heavy and drain-heavy stretches to visit full and empty
      push_pct = ((k / 40) % 2 == 0) ? 70 : 30;
      r = $urandom_range(0, 99);
      if (r < 4) begin
        act = ACT_NONE;
        value = $urandom;
      end else if (r < push_pct) begin
        act = ACT_PUSH;
        value = pick_value();
      end else if ($urandom_range(0, 1) == 0) begin
        act = ACT_POP;
        value = $urandom;
      end else begin
        act = ACT_REMOVE;
        if (tracker.held > 0 && $urandom_range(0, 2) != 0)
          value = tracker.slots[$urandom_range(0, tracker.held - 1)];
        else
          value = pick_value();
      end
      send_request(act, value);
    end

    @(negedge clk);
    in_tvalid <= 1'b0;
    while (tracker.pending_results.size() != 0) @(posedge clk);
    repeat (40) @(posedge clk);
    if (tracker.pending_results.size() != 0)
      tracker.flag_fault("result items still outstanding at end");
    if (tracker.fault_count == 0) begin
      $display("stack_with_value_removal_unit: match");
    end else begin
      $display("stack_with_value_removal_unit: mismatch");
    end
    $finish;
  end

endmodule
